[hdl/lohl_pkg.sv]
// Shared constants, register indexes and beat layouts for the lead object hold latch.
package lohl_pkg;

	localparam int STREAK_BITS = 8;
	localparam int CMP_BITS    = (STREAK_BITS > 8) ? STREAK_BITS : 8;

	localparam int DIST_W   = 18;
	localparam int SPEED_W  = 17;
	localparam int GATE_W   = 16;
	localparam int COUNT_W  = 8;
	localparam int DT_W     = 11;
	localparam int REL_O_W  = 18;
	localparam int TRAVEL_W = 40;
	localparam int INC_W    = 16;

	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 40;
	localparam int CFG_IDX_W  = 3;

	localparam logic [DIST_W-1:0] FREE_ROAD_MM = DIST_W'(150000);
	localparam logic [STREAK_BITS-1:0] STREAK_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_LATCH_DIST  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_GATE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_CNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ARM_CNT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_JUMP_GATE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_FLOOR   = 3'd5;

	typedef struct packed {
		logic                      detected;
		logic [DIST_W-1:0]         dist_mm;
		logic signed [SPEED_W-1:0] rel;
		logic signed [SPEED_W-1:0] own;
		logic [DT_W-1:0]           dt;
	} frame_t;

endpackage

[hdl/lead_object_hold_latch.sv]
// Lead object hold latch: top level with travel integration, streak counting and loss latch.
//
// One frame goes in per beat and one result comes out per beat; a new frame can be
// taken every cycle unless the result is held by m_tready low. A frame passes three
// registers: an input register, a stage that forms own travel (own speed times elapsed
// ticks), and the stage that updates the tracked state and loads the result register.
// The state update is registered with the result, so frames follow back to back.
// Configuration writes are taken at any time but should only be made while idle.
module lead_object_hold_latch
	import lohl_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_DATA_W-1:0]   s_tdata,  // measured_dist_mm, measured_rel_speed, own_speed, elapsed_ticks, zero pad
	input  logic                   s_tuser,  // detected
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_DATA_W-1:0]  m_tdata,  // lead_dist_mm, lead_rel_speed, hold_active, zero pad
	output logic                   m_tuser,  // lead_present
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [DIST_W-1:0]      cfg_data
);

	// config registers
	logic [DIST_W-1:0]  latch_dist_q;
	logic [GATE_W-1:0]  speed_gate_q;
	logic [COUNT_W-1:0] release_cnt_q;
	logic [COUNT_W-1:0] arm_cnt_q;
	logic [DIST_W-1:0]  jump_gate_q;
	logic [DIST_W-1:0]  gap_floor_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_dist_q  <= DIST_W'(10000);
			speed_gate_q  <= GATE_W'(3000);
			release_cnt_q <= COUNT_W'(5);
			arm_cnt_q     <= COUNT_W'(10);
			jump_gate_q   <= DIST_W'(4000);
			gap_floor_q   <= DIST_W'(500);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_LATCH_DIST:  latch_dist_q  <= cfg_data;
				REG_SPEED_GATE:  speed_gate_q  <= cfg_data[GATE_W-1:0];
				REG_RELEASE_CNT: release_cnt_q <= cfg_data[COUNT_W-1:0];
				REG_ARM_CNT:     arm_cnt_q     <= cfg_data[COUNT_W-1:0];
				REG_JUMP_GATE:   jump_gate_q   <= cfg_data;
				REG_GAP_FLOOR:   gap_floor_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline flow
	logic   valid_s1, valid_s2, out_valid_q;
	logic   adv_out, adv_s2, adv_s1;
	frame_t frame_s1, frame_s2;
	logic [INC_W-1:0] inc_s2;

	assign adv_out  = !out_valid_q || m_tready;
	assign adv_s2   = !valid_s2 || adv_out;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= s_tvalid;
			if (adv_s2)
				valid_s2 <= valid_s1;
			if (adv_out)
				out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			frame_s1.detected <= s_tuser;
			frame_s1.dist_mm  <= s_tdata[17:0];
			frame_s1.rel      <= s_tdata[34:18];
			frame_s1.own      <= s_tdata[51:35];
			frame_s1.dt       <= s_tdata[62:52];
		end
	end

	// own travel for this frame, in mm
	logic        travel_en;
	logic [25:0] travel_prod;

	assign travel_en = (frame_s1.dt != '0) && !frame_s1.dt[DT_W-1]
		&& !frame_s1.own[SPEED_W-1] && (frame_s1.own != '0);
	assign travel_prod = frame_s1.own[15:0] * frame_s1.dt[9:0];

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			frame_s2 <= frame_s1;
			inc_s2   <= travel_en ? travel_prod[25:10] : '0;
		end
	end

	// tracked state
	logic [DIST_W-1:0]      remembered_q;
	logic [TRAVEL_W-1:0]    since_q;   // travel since last confirm, mod 2^40
	logic [STREAK_BITS-1:0] streak_q;
	logic                   hold_q;

	logic                   step;
	logic [STREAK_BITS-1:0] streak_inc;
	logic                   trusted, plausible, solid, slow, latch_now, confirm;
	logic [DIST_W-1:0]      diff;
	logic [TRAVEL_W-1:0]    moved;
	logic [DIST_W-1:0]      gap_raw, gap;
	logic                   hold_next;

	assign step       = valid_s2 && adv_out;
	assign streak_inc = (streak_q == STREAK_MAX) ? streak_q : streak_q + 1'b1;
	assign trusted    = CMP_BITS'(streak_inc) >= CMP_BITS'(release_cnt_q);
	assign diff       = (frame_s2.dist_mm >= remembered_q) ? frame_s2.dist_mm - remembered_q
		: remembered_q - frame_s2.dist_mm;
	assign plausible  = (remembered_q >= latch_dist_q) || (diff < jump_gate_q);
	assign confirm    = frame_s2.detected && trusted && plausible;

	assign solid     = CMP_BITS'(streak_q) >= CMP_BITS'(arm_cnt_q);
	assign slow      = $signed({frame_s2.own[SPEED_W-1], frame_s2.own})
		< $signed({2'b00, speed_gate_q});
	assign latch_now = !frame_s2.detected && solid && (remembered_q < latch_dist_q) && slow;

	assign moved   = since_q + TRAVEL_W'(inc_s2);
	assign gap_raw = (TRAVEL_W'(remembered_q) > moved) ? remembered_q - moved[DIST_W-1:0] : '0;
	assign gap     = (gap_raw < gap_floor_q) ? gap_floor_q : gap_raw;

	always_comb begin
		hold_next = hold_q;
		if (frame_s2.detected && trusted)
			hold_next = 1'b0;
		else if (latch_now)
			hold_next = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remembered_q <= FREE_ROAD_MM;
			since_q      <= '0;
			streak_q     <= '0;
			hold_q       <= 1'b0;
		end else if (step) begin
			since_q  <= confirm ? '0 : moved;
			streak_q <= frame_s2.detected ? streak_inc : '0;
			hold_q   <= hold_next;
			if (confirm)
				remembered_q <= frame_s2.dist_mm;
		end
	end

	// result register
	logic [DIST_W-1:0]  res_dist_q;
	logic [REL_O_W-1:0] res_rel_q;
	logic               res_present_q, res_hold_q;

	always_ff @(posedge clk) begin
		if (step) begin
			res_hold_q <= hold_next;
			if (latch_now) begin
				res_present_q <= 1'b1;
				res_dist_q    <= gap;
				res_rel_q     <= -{frame_s2.own[SPEED_W-1], frame_s2.own};
			end else begin
				res_present_q <= frame_s2.detected;
				res_dist_q    <= frame_s2.dist_mm;
				res_rel_q     <= {frame_s2.rel[SPEED_W-1], frame_s2.rel};
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_present_q;
	assign m_tdata  = {3'b000, res_hold_q, res_rel_q, res_dist_q};

	// checks
	a_latched_gap_floor: assert property (@(posedge clk) disable iff (!arst_n)
		step && latch_now |=> m_tdata[17:0] >= $past(gap_floor_q))
		else $error("latched gap below floor");

	a_trusted_clears_hold: assert property (@(posedge clk) disable iff (!arst_n)
		step && frame_s2.detected && trusted |=> !hold_q && !m_tdata[36])
		else $error("trusted detection left hold set");

	a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

endmodule

[test/lead_object_hold_latch_test.sv]
// Self-checking testbench for the lead object hold latch: predicted reports, random frames, stalls.
`timescale 1ns / 100ps

module lead_object_hold_latch_test;
	import lohl_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		bit                       present;
		bit [DIST_W-1:0]          dist_mm;
		bit [REL_O_W-1:0]         rel;
		bit                       hold;
	} lead_report_t;

	class lead_report_board;
		logic [DIST_W-1:0]      latch_mm;
		logic [GATE_W-1:0]      gate_mm_s;
		logic [COUNT_W-1:0]     trust_runs;
		logic [COUNT_W-1:0]     arm_runs;
		logic [DIST_W-1:0]      jump_mm;
		logic [DIST_W-1:0]      floor_mm;

		logic [DIST_W-1:0]      remembered_mm;
		logic [TRAVEL_W-1:0]    travel_mm;
		logic [TRAVEL_W-1:0]    travel_at_fix;
		logic [STREAK_BITS-1:0] streak;
		bit                     latched;

		lead_report_t           pending_reports[$];
		int                     errors;

		function new();
			latch_mm      = DIST_W'(10000);
			gate_mm_s     = GATE_W'(3000);
			trust_runs    = COUNT_W'(5);
			arm_runs      = COUNT_W'(10);
			jump_mm       = DIST_W'(4000);
			floor_mm      = DIST_W'(500);
			remembered_mm = FREE_ROAD_MM;
			travel_mm     = '0;
			travel_at_fix = '0;
			streak        = '0;
			latched       = 1'b0;
			errors        = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIST_W-1:0] val);
			case (idx)
				REG_LATCH_DIST:  latch_mm   = val;
				REG_SPEED_GATE:  gate_mm_s  = val[GATE_W-1:0];
				REG_RELEASE_CNT: trust_runs = val[COUNT_W-1:0];
				REG_ARM_CNT:     arm_runs   = val[COUNT_W-1:0];
				REG_JUMP_GATE:   jump_mm    = val;
				REG_GAP_FLOOR:   floor_mm   = val;
				default: ;
			endcase
		endfunction

		function int pending();
			return pending_reports.size();
		endfunction

		function void note_frame(frame_t f);
			lead_report_t        r;
			logic [DIST_W-1:0]   diff;
			logic [TRAVEL_W-1:0] moved;
			logic [TRAVEL_W-1:0] gap;
			logic [27:0]         step;
			logic [REL_O_W-1:0]  own_x;
			bit                  trusted;
			bit                  plausible;
			bit                  solid;
			own_x = {f.own[SPEED_W-1], f.own};
			if (f.dt != '0 && f.dt < DT_W'(1024) && $signed(f.own) > 0) begin
				step = (28'(f.own[SPEED_W-2:0]) * 28'(f.dt)) >> 10;
				travel_mm = travel_mm + TRAVEL_W'(step);
			end
			r.present = 1'b1;
			r.dist_mm = f.dist_mm;
			r.rel     = {f.rel[SPEED_W-1], f.rel};
			if (f.detected) begin
				if (streak != STREAK_MAX)
					streak = streak + 1'b1;
				trusted = streak >= trust_runs;
				diff = (f.dist_mm >= remembered_mm) ? f.dist_mm - remembered_mm
					: remembered_mm - f.dist_mm;
				plausible = remembered_mm >= latch_mm || diff < jump_mm;
				if (trusted && plausible) begin
					remembered_mm = f.dist_mm;
					travel_at_fix = travel_mm;
				end
				if (trusted)
					latched = 1'b0;
			end else begin
				solid = streak >= arm_runs;
				streak = '0;
				if (solid && remembered_mm < latch_mm
						&& $signed(f.own) < $signed({1'b0, gate_mm_s})) begin
					moved = travel_mm - travel_at_fix;
					gap = (TRAVEL_W'(remembered_mm) > moved) ? TRAVEL_W'(remembered_mm) - moved : '0;
					if (gap < TRAVEL_W'(floor_mm))
						gap = TRAVEL_W'(floor_mm);
					latched   = 1'b1;
					r.dist_mm = gap[DIST_W-1:0];
					r.rel     = REL_O_W'(0) - own_x;
				end else begin
					r.present = 1'b0;
				end
			end
			r.hold = latched;
			pending_reports.push_back(r);
		endfunction

		function void flag(string field, longint unsigned want, longint unsigned got);
			errors++;
			$error("%s: expected %0d, got %0d", field, want, got);
		endfunction

		function void check_report(bit present, bit [DIST_W-1:0] dist_mm, bit [REL_O_W-1:0] rel,
				bit hold);
			lead_report_t w;
			if (pending_reports.size() == 0) begin
				flag("unexpected result beat, lead_dist_mm", 0, dist_mm);
				return;
			end
			w = pending_reports.pop_front();
			if (w.present != present) flag("lead_present", w.present, present);
			if (w.dist_mm != dist_mm) flag("lead_dist_mm", w.dist_mm, dist_mm);
			if (w.rel != rel)         flag("lead_rel_speed", w.rel, rel);
			if (w.hold != hold)       flag("hold_active", w.hold, hold);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [DIST_W-1:0]     cfg_data;

	lead_report_board sb;
	bit               calm;
	int               sink_hold;
	int               frames_sent;
	int               cycle_count;

	lead_object_hold_latch u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("lead_object_hold_latch_test: done, errors");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off when requested
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (sink_hold > 0) begin
			m_tready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= 30);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_report(m_tuser, m_tdata[DIST_W-1:0], m_tdata[DIST_W+REL_O_W-1:DIST_W],
				m_tdata[DIST_W+REL_O_W]);
	end

	function automatic frame_t make_frame(bit det, int dist_mm, int rel, int own, int dt);
		frame_t f;
		f.detected = det;
		f.dist_mm  = DIST_W'(dist_mm);
		f.rel      = SPEED_W'(rel);
		f.own      = SPEED_W'(own);
		f.dt       = DT_W'(dt);
		return f;
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_frame(frame_t f);
		while (!calm && $urandom_range(99) < 30) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= f.detected;
		s_tdata  <= {1'b0, f.dt, f.own, f.rel, f.dist_mm};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_frame(f);
		frames_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_settings(int latch, int gate, int trust, int arm, int jump, int flr);
		logic [DIST_W-1:0] vals[6];
		logic [CFG_IDX_W-1:0] idxs[6];
		vals = '{DIST_W'(latch), DIST_W'(gate), DIST_W'(trust), DIST_W'(arm),
			DIST_W'(jump), DIST_W'(flr)};
		idxs = '{REG_LATCH_DIST, REG_SPEED_GATE, REG_RELEASE_CNT, REG_ARM_CNT,
			REG_JUMP_GATE, REG_GAP_FLOOR};
		for (int i = 0; i < 6; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idxs[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			sb.write_reg(idxs[i], vals[i]);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// a run of detections near a drifting distance, then a loss that may latch
	task automatic run_track();
		int base, n, w, own, dt, losses;
		base = ($urandom_range(3) == 0) ? $urandom_range(262143)
			: $urandom_range(sb.latch_mm > 0 ? sb.latch_mm - 1 : 0);
		n = ($urandom_range(11) == 0) ? $urandom_range(200, 300) : $urandom_range(1, 25);
		w = (sb.jump_mm > 3000) ? 750 : sb.jump_mm / 4;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(11) == 0)
				base = base + $urandom_range(40000) - 20000;
			else
				base = base + $urandom_range(2 * w) - w;
			if (base < 0) base = 0;
			if (base > 262143) base = 262143;
			own = ($urandom_range(7) == 0) ? $urandom_range(131071) - 65536
				: $urandom_range(8000) - 500;
			dt = ($urandom_range(14) == 0) ? $urandom_range(2047) : $urandom_range(1, 200);
			send_frame(make_frame(1'b1, base, $urandom_range(20000) - 10000, own, dt));
		end
		losses = $urandom_range(1, 4);
		for (int k = 0; k < losses; k++) begin
			if (k == 0 && sb.gate_mm_s > 0 && $urandom_range(3) != 0)
				own = $urandom_range(sb.gate_mm_s - 1);
			else
				own = $urandom_range(131071) - 65536;
			dt = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(1, 1023);
			send_frame(make_frame(1'b0, $urandom_range(262143), $urandom_range(131071) - 65536,
				own, dt));
		end
	endtask

	task automatic run_phase(int count, bit pressure);
		int stop;
		bit held;
		bit paused;
		stop = frames_sent + count;
		held = 1'b0;
		paused = 1'b0;
		while (frames_sent < stop) begin
			if (pressure && !held && frames_sent > stop - 2 * count / 3) begin
				sink_hold = 300;
				held = 1'b1;
			end
			if (pressure && !paused && frames_sent > stop - count / 3) begin
				wait_drained();
				paused = 1'b1;
			end
			if ($urandom_range(9) < 2) begin
				repeat ($urandom_range(1, 3))
					send_frame(make_frame($urandom_range(1), $urandom, $urandom, $urandom,
						$urandom));
			end else begin
				run_track();
			end
		end
	endtask

	initial begin
		sb          = new();
		calm        = 1'b0;
		sink_hold   = 0;
		frames_sent = 0;
		cycle_count = 0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = 1'b0;
		m_tready    = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// field extremes, elapsed time zero and out of range
		send_frame(make_frame(1'b0, 0, 0, 0, 0));
		send_frame(make_frame(1'b1, 262143, -65536, 65535, 1023));
		send_frame(make_frame(1'b1, 0, 65535, -65536, 2047));
		// armed close target lost at low speed: latches at coasted gap
		for (int k = 0; k < 10; k++)
			send_frame(make_frame(1'b1, 5000, -300, 1000, 100));
		send_frame(make_frame(1'b0, 1234, 77, 500, 512));
		// loss while unarmed: no report, latch holds
		send_frame(make_frame(1'b0, 9999, -5, 100, 1024));
		// detections too far off to confirm, then a loss: latches at the coasted gap
		for (int k = 0; k < 10; k++)
			send_frame(make_frame(1'b1, 600, 0, 0, 0));
		send_frame(make_frame(1'b0, 0, 0, 2999, 1023));

		run_phase(280, 1'b0);
		wait_drained();
		write_settings(262143, 65535, 1, 1, 0, 262143);
		run_phase(300, 1'b0);
		wait_drained();
		write_settings(0, 0, 255, 255, 262143, 0);
		run_phase(300, 1'b0);
		wait_drained();
		write_settings($urandom_range(5000, 40000), $urandom_range(1000, 10000),
			$urandom_range(1, 8), $urandom_range(1, 15), $urandom_range(500, 8000),
			$urandom_range(2000));
		calm = 1'b1;
		run_phase(300, 1'b0);
		calm = 1'b0;
		wait_drained();
		write_settings($urandom_range(262143), $urandom_range(65535), $urandom_range(1, 255),
			$urandom_range(1, 255), $urandom_range(262143), $urandom_range(262143));
		run_phase(300, 1'b0);
		wait_drained();
		write_settings($urandom_range(5000, 40000), $urandom_range(1000, 10000),
			$urandom_range(1, 8), $urandom_range(1, 15), $urandom_range(500, 8000),
			$urandom_range(2000));
		run_phase(300, 1'b1);

		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("lead_object_hold_latch_test: done, clean");
		else
			$display("lead_object_hold_latch_test: done, errors");
		$finish;
	end

endmodule

[files.f]
hdl/lohl_pkg.sv
hdl/lead_object_hold_latch.sv
test/lead_object_hold_latch_test.sv
